@@ rtl/assert_macros.svh @@
// Assertion macros used by the matcher core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked while out of reset
`define RHPM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked while out of reset
`define RHPM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/rhpm_pkg.sv @@
// Shared types, constants and the mod-101 hash step of the pattern matcher.
package rhpm_pkg;

    // Hash arithmetic: base 256 modulo 101
    localparam int unsigned HASH_MOD  = 101;
    localparam int unsigned BASE_RES  = 54;   // 256 mod 101
    localparam int unsigned RECIP     = 648;  // floor(2^16 / 101), underestimates
    localparam int unsigned RECIP_SH  = 16;

    // Pattern storage
    localparam int unsigned PATTERN_BYTES = 32;
    localparam int unsigned PATTERN_REGS  = 4;

    // Bus widths
    localparam int unsigned APB_AW     = 6;
    localparam int unsigned APB_DW     = 64;
    localparam int unsigned S_TDATA_W  = 8;
    localparam int unsigned M_TDATA_W  = 24;

    typedef logic [6:0] hash_t;

    // Register index codes (byte address / 8)
    typedef enum logic [2:0] {
        CFG_LENGTH = 3'd0,
        CFG_PAT0   = 3'd1,
        CFG_PAT1   = 3'd2,
        CFG_PAT2   = 3'd3,
        CFG_PAT3   = 3'd4
    } cfg_index_t;

    // Pattern side status seen by the datapath
    typedef struct packed {
        logic  busy;
        hash_t phash;
    } pat_status_t;

    // One Horner step: (acc * 256 + data) mod 101
    function automatic hash_t hash_step(input hash_t acc, input logic [7:0] data);
        logic [12:0] x;
        logic [22:0] prod;
        logic [6:0]  q;
        logic [12:0] r;
        x    = 13'(acc) * 13'(BASE_RES) + 13'(data);
        prod = 23'(x) * 23'(RECIP);
        q    = 7'(prod >> RECIP_SH);
        r    = x - 13'(q) * 13'(HASH_MOD);
        // quotient estimate is at most one low
        if (r >= 13'(HASH_MOD)) begin
            r = r - 13'(HASH_MOD);
        end
        return r[6:0];
    endfunction

endpackage

@@ rtl/rhpm_pattern_ctrl.sv @@
// Configuration registers, APB access and the pattern hash / alignment pass.
module rhpm_pattern_ctrl #(
    parameter int unsigned MAX_PATTERN = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rhpm_pkg::APB_AW-1:0]   paddr,
    input  logic [rhpm_pkg::APB_DW-1:0]   pwdata,
    output logic [rhpm_pkg::APB_DW-1:0]   prdata,
    output logic                          pready,
    output logic [$clog2(MAX_PATTERN+1)-1:0] len_eff,
    output logic [7:0]                    target [MAX_PATTERN],
    output rhpm_pkg::pat_status_t         status
);

    localparam int unsigned LEN_W = $clog2(MAX_PATTERN + 1);
    localparam int unsigned IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

    logic [5:0]                  len_reg;
    logic [rhpm_pkg::APB_DW-1:0] pat0_reg, pat1_reg, pat2_reg, pat3_reg;
    logic                        busy_reg;
    logic [LEN_W-1:0]            cnt_reg;
    rhpm_pkg::hash_t             acc_reg;
    rhpm_pkg::hash_t             phash_reg;
    logic [7:0]                  target_reg [MAX_PATTERN];

    logic                        wr_en;
    rhpm_pkg::cfg_index_t        reg_idx;
    logic [6:0]                  len_wide;
    logic [6:0]                  len_clamped;
    logic [4*rhpm_pkg::APB_DW-1:0] pat_all;
    logic [6:0]                  byte_idx;
    logic [7:0]                  pat_byte;
    rhpm_pkg::hash_t             acc_next;
    logic [LEN_W-1:0]            tgt_pos;
    logic                        pass_done;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = rhpm_pkg::cfg_index_t'(paddr[5:3]);

    // Effective length: 0 acts as 1, capped at the window depth
    always_comb begin
        len_wide = {1'b0, len_reg};
        if (len_wide == 7'd0) begin
            len_clamped = 7'd1;
        end else if (len_wide > 7'(MAX_PATTERN)) begin
            len_clamped = 7'(MAX_PATTERN);
        end else begin
            len_clamped = len_wide;
        end
    end
    assign len_eff = LEN_W'(len_clamped);

    // Register read
    always_comb begin
        unique case (reg_idx)
            rhpm_pkg::CFG_LENGTH: prdata = rhpm_pkg::APB_DW'(len_reg);
            rhpm_pkg::CFG_PAT0:   prdata = pat0_reg;
            rhpm_pkg::CFG_PAT1:   prdata = pat1_reg;
            rhpm_pkg::CFG_PAT2:   prdata = pat2_reg;
            rhpm_pkg::CFG_PAT3:   prdata = pat3_reg;
            default:              prdata = '0;
        endcase
    end

    // Pattern byte at the pass counter; bytes past the register file read zero
    assign pat_all  = {pat3_reg, pat2_reg, pat1_reg, pat0_reg};
    assign byte_idx = 7'(cnt_reg);
    assign pat_byte = (byte_idx < 7'(rhpm_pkg::PATTERN_BYTES))
                    ? pat_all[{byte_idx[4:0], 3'b000} +: 8] : 8'd0;

    assign acc_next  = rhpm_pkg::hash_step(acc_reg, pat_byte);
    assign tgt_pos   = len_eff - LEN_W'(1) - cnt_reg;
    assign pass_done = (cnt_reg == len_eff - LEN_W'(1));

    // Register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg  <= 6'd1;
            pat0_reg <= '0;
            pat1_reg <= '0;
            pat2_reg <= '0;
            pat3_reg <= '0;
        end else if (wr_en) begin
            unique case (reg_idx)
                rhpm_pkg::CFG_LENGTH: len_reg  <= pwdata[5:0];
                rhpm_pkg::CFG_PAT0:   pat0_reg <= pwdata;
                rhpm_pkg::CFG_PAT1:   pat1_reg <= pwdata;
                rhpm_pkg::CFG_PAT2:   pat2_reg <= pwdata;
                rhpm_pkg::CFG_PAT3:   pat3_reg <= pwdata;
                default: ;
            endcase
        end
    end

    // Pattern pass: one byte a cycle, Horner hash plus reversed copy for compare
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b1;
            cnt_reg   <= '0;
            acc_reg   <= '0;
            phash_reg <= '0;
        end else if (wr_en) begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
            acc_reg  <= '0;
        end else if (busy_reg) begin
            acc_reg <= acc_next;
            cnt_reg <= cnt_reg + LEN_W'(1);
            if (pass_done) begin
                busy_reg  <= 1'b0;
                phash_reg <= acc_next;
            end
        end
    end

    // Aligned pattern: target[k] = pattern byte (len-1-k)
    always_ff @(posedge aclk) begin
        if (aresetn && !wr_en && busy_reg) begin
            target_reg[tgt_pos[IDX_W-1:0]] <= pat_byte;
        end
    end

    assign target       = target_reg;
    assign status.busy  = busy_reg;
    assign status.phash = phash_reg;

endmodule

@@ rtl/rhpm_hash_lanes.sv @@
// Text window and per-length prefix hash lanes, updated once per accepted byte.
module rhpm_hash_lanes #(
    parameter int unsigned MAX_PATTERN = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          accept,
    input  logic [7:0]                    text_byte,
    input  logic                          restart,
    input  logic [$clog2(MAX_PATTERN+1)-1:0] len_eff,
    output logic [7:0]                    win_next [MAX_PATTERN],
    output rhpm_pkg::hash_t               hash_next,
    output logic                          win_full
);

    localparam int unsigned LEN_W = $clog2(MAX_PATTERN + 1);
    localparam int unsigned IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

    // lane_reg[k] holds the hash of the newest k+1 bytes
    logic [7:0]       window_reg [MAX_PATTERN];
    rhpm_pkg::hash_t  lane_reg   [MAX_PATTERN];
    logic [LEN_W-1:0] seen_reg;

    rhpm_pkg::hash_t  lane_next [MAX_PATTERN];
    logic [LEN_W-1:0] seen_src;
    logic [LEN_W-1:0] seen_clamped;
    logic [LEN_W-1:0] seen_next;
    logic [LEN_W-1:0] sel_pos;

    // Shift in the new byte; restart drops the old contents
    always_comb begin
        win_next[0]  = text_byte;
        lane_next[0] = rhpm_pkg::hash_step('0, text_byte);
        for (int k = 1; k < MAX_PATTERN; k++) begin
            win_next[k]  = restart ? 8'd0 : window_reg[k-1];
            lane_next[k] = rhpm_pkg::hash_step(restart ? '0 : lane_reg[k-1], text_byte);
        end
    end

    // Fill count, clamped to the current length
    always_comb begin
        seen_src     = restart ? '0 : seen_reg;
        seen_clamped = (seen_src > len_eff) ? len_eff : seen_src;
        seen_next    = (seen_clamped < len_eff) ? seen_clamped + LEN_W'(1) : len_eff;
    end

    assign sel_pos   = seen_next - LEN_W'(1);
    assign hash_next = lane_next[sel_pos[IDX_W-1:0]];
    assign win_full  = (seen_next == len_eff);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg <= '0;
        end else if (accept) begin
            seen_reg <= seen_next;
        end
    end

    // Window and lanes carry payload only
    always_ff @(posedge aclk) begin
        if (accept) begin
            window_reg <= win_next;
            lane_reg   <= lane_next;
        end
    end

endmodule

@@ rtl/rolling_hash_pattern_matcher_core.sv @@
// Top level: stream handshake, text position, window compare and result register.
// An accepted text byte's result is in the output register in the next cycle; that register
// takes a new result while the old one leaves. Throughput: one byte per cycle outside a pattern
// pass and while m_tready is high. After reset and after every register write, a pattern pass over
// pattern_length bytes (1 to MAX_PATTERN) hashes and aligns the pattern; s_tready is held low.
// Reset (aresetn, synchronous, active low) sets length 1, pattern zero, empty window, position 0.
`include "assert_macros.svh"

module rolling_hash_pattern_matcher_core #(
    parameter int unsigned      MAX_PATTERN = 32,
    parameter longint unsigned  MAX_TEXT    = 65536
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // APB configuration
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [rhpm_pkg::APB_AW-1:0]         paddr,
    input  logic [rhpm_pkg::APB_DW-1:0]         pwdata,
    output logic [rhpm_pkg::APB_DW-1:0]         prdata,
    output logic                                pready,
    // Text input
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [rhpm_pkg::S_TDATA_W-1:0]      s_tdata,   // [7:0] text_byte
    input  logic                                s_tuser,   // [0] restart
    // Results
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [rhpm_pkg::M_TDATA_W-1:0]      m_tdata    // [0] hash_hit, [1] match,
                                                           // [17:2] match_start, [23:18] zero
);

    localparam int unsigned LEN_W = $clog2(MAX_PATTERN + 1);
    localparam int unsigned POS_W = $clog2(MAX_TEXT);
    localparam logic [POS_W:0] TEXT_LIMIT = (POS_W+1)'(MAX_TEXT);

    logic [LEN_W-1:0]            len_eff;
    logic [7:0]                  target [MAX_PATTERN];
    rhpm_pkg::pat_status_t       status;
    logic [7:0]                  win_next [MAX_PATTERN];
    rhpm_pkg::hash_t             hash_next;
    logic                        win_full;

    logic                        accept_in;
    logic                        m_tvalid_reg;
    logic [rhpm_pkg::M_TDATA_W-1:0] m_tdata_reg;
    logic [POS_W-1:0]            pos_reg;

    logic [POS_W:0]              pos_src;
    logic [POS_W:0]              pos_inc;
    logic [POS_W:0]              len_m1;
    logic [POS_W:0]              start_pos;
    logic [MAX_PATTERN-1:0]      byte_ok;
    logic                        hit;
    logic                        full_match;
    logic [15:0]                 match_start;

    rhpm_pattern_ctrl #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_pattern (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .len_eff (len_eff),
        .target  (target),
        .status  (status)
    );

    rhpm_hash_lanes #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_lanes (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (accept_in),
        .text_byte (s_tdata),
        .restart   (s_tuser),
        .len_eff   (len_eff),
        .win_next  (win_next),
        .hash_next (hash_next),
        .win_full  (win_full)
    );

    // Handshake: the output register frees up in the same cycle it is taken
    assign s_tready  = !status.busy && (!m_tvalid_reg || m_tready);
    assign accept_in = s_tvalid && s_tready;

    // Text position and window start, modulo the text limit
    always_comb begin
        pos_src = s_tuser ? '0 : {1'b0, pos_reg};
        pos_inc = pos_src + (POS_W+1)'(1);
        len_m1  = (POS_W+1)'(len_eff - LEN_W'(1));
        if (pos_src >= len_m1) begin
            start_pos = pos_src - len_m1;
        end else begin
            start_pos = pos_src + TEXT_LIMIT - len_m1;
        end
    end

    // Byte-for-byte compare against the aligned pattern
    always_comb begin
        for (int k = 0; k < MAX_PATTERN; k++) begin
            byte_ok[k] = (k >= int'(len_eff)) || (win_next[k] == target[k]);
        end
    end

    assign hit         = win_full && (hash_next == status.phash);
    assign full_match  = hit && (&byte_ok);
    assign match_start = full_match ? 16'(start_pos) : 16'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (accept_in) begin
                pos_reg      <= (pos_inc == TEXT_LIMIT) ? '0 : POS_W'(pos_inc);
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        if (accept_in) begin
            m_tdata_reg <= {6'd0, match_start, full_match, hit};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Checks
    `RHPM_ASSERT_NOW(a_match_needs_hit, aclk, aresetn, m_tvalid && m_tdata[1], m_tdata[0], "match without hash hit")
    `RHPM_ASSERT_NOW(a_start_zero, aclk, aresetn, m_tvalid && !m_tdata[1], m_tdata[17:2] == 16'd0, "match_start set without match")
    `RHPM_ASSERT_NOW(a_no_take_in_pass, aclk, aresetn, status.busy, !accept_in, "byte taken during pattern pass")
    `RHPM_ASSERT_NEXT(a_restart_pos, aclk, aresetn, accept_in && s_tuser, pos_reg == POS_W'(1), "position not reset by restart")

endmodule
